/* hw/rtl/rbb_pkg.sv */
// shared types and constants for the rgb 3x3 box blur
package rbb_pkg;

    localparam int PIX_W     = 8;
    localparam int NUM_CH    = 3;
    localparam int IN_W      = PIX_W * NUM_CH;
    localparam int OUT_W     = PIX_W * 4;
    localparam int REG_W     = 13;
    localparam int ROW_W     = 12;
    localparam int SUM_W     = 12;
    localparam int MAX_HEIGHT = 4096;

    // floor(s / 10) == (s * 6554) >> 16 for every s up to 9 * 255
    localparam int          RECIP_W   = 13;
    localparam int          PROD_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV10_RECIP = 13'd6554;
    localparam int          RECIP_SH  = 16;
    localparam logic [SUM_W-1:0]   SUM_MAX = 12'd2295;
    localparam logic [PIX_W-1:0]   BLUR_MAX = 8'd229;

    localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_index;

    localparam logic [REG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [REG_W-1:0] HEIGHT_RESET = 13'd480;

    typedef logic [IN_W-1:0]  t_pix;
    typedef logic [SUM_W-1:0] t_sum;

endpackage

/* hw/rtl/rgb_box_blur_3x3.sv */
// rgb 3x3 box blur with two line stores and a sliding window
//
// Pixels enter in raster order, one item per clock when both sides keep
// up. A read and a write of each line store per item (one port each) and
// a three-stage pipeline (line store read, window and channel sums,
// divide by ten) let a new item enter while earlier ones are in flight.
// Only interior pixels give a result; each channel is floor(sum of the
// 3x3 neighborhood / 10), alpha is 255, and tlast marks the last interior
// pixel of the frame. Width and height are written over the cfg port;
// the user must write them only while the block is idle, and the block
// itself does not enforce it. Values are clamped to 3..MAX_WIDTH and
// 3..4096. No clearing pass is needed after reset.
module rgb_box_blur_3x3 #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // cfg write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  rbb_pkg::t_cfg_index      i_cfg_index,
    input  logic [rbb_pkg::REG_W-1:0] i_cfg_data,
    // pixel input
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [rbb_pkg::IN_W-1:0] s_axis_tdata,  // pix_red, pix_green, pix_blue
    // blurred output
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [rbb_pkg::OUT_W-1:0] m_axis_tdata, // out_red, out_green, out_blue, out_alpha
    output logic                     m_axis_tlast   // frame_end
);
    import rbb_pkg::*;

    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int XW = (CW + 1 > REG_W) ? CW + 1 : REG_W;

    // configuration
    logic [REG_W-1:0] r_width;
    logic [REG_W-1:0] r_height;

    // position of the next pixel
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;

    // line stores
    t_pix r_upper_line  [MAX_WIDTH];
    t_pix r_middle_line [MAX_WIDTH];

    // stage a: pixel and line store read data
    logic          r_a_v;
    t_pix          r_a_pix;
    t_pix          r_a_top;
    t_pix          r_a_mid;
    logic [CW-1:0] r_a_col;
    logic          r_a_int;
    logic          r_a_last;

    // window, entries 0..8 in row-major order, newest column on the right
    t_pix r_win [9];
    t_pix n_win [9];

    // stage s: channel sums
    logic r_s_v;
    t_sum r_s_sum [NUM_CH];
    t_sum n_sum   [NUM_CH];
    logic r_s_last;

    // output register
    logic             r_out_v;
    logic [OUT_W-1:0] r_out_data;
    logic             r_out_last;
    logic [OUT_W-1:0] n_out_data;

    logic en_out, en_s, en_a, acc_in, adv_a;

    logic [XW-1:0]    w_x;
    logic [XW-1:0]    w_m1;
    logic [REG_W-1:0] h_m1;
    logic             col_last, row_last;

    logic [PROD_W-1:0] prod [NUM_CH];

    assign o_cfg_ready = 1'b1;

    // handshake chain: each stage moves when the next one is empty or moving
    assign en_out = !r_out_v || m_axis_tready;
    assign en_s   = !r_s_v || en_out;
    assign en_a   = !r_a_v || en_s;
    assign acc_in = s_axis_tvalid && en_a;
    assign adv_a  = r_a_v && en_s;

    assign s_axis_tready = en_a;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // clamped limits
    always_comb begin
        w_x = XW'(r_width);
        if (w_x < XW'(3)) begin
            w_m1 = XW'(2);
        end else if (w_x > XW'(MAX_WIDTH)) begin
            w_m1 = XW'(MAX_WIDTH - 1);
        end else begin
            w_m1 = w_x - XW'(1);
        end
        if (r_height < REG_W'(3)) begin
            h_m1 = REG_W'(2);
        end else if (r_height > REG_W'(MAX_HEIGHT)) begin
            h_m1 = REG_W'(MAX_HEIGHT - 1);
        end else begin
            h_m1 = r_height - REG_W'(1);
        end
        col_last = (XW'(r_col) >= w_m1);
        row_last = (REG_W'(r_row) >= h_m1);
    end

    // config and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                    CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    default:          r_width  <= r_width;
                endcase
            end
            if (acc_in) begin
                if (col_last) begin
                    r_col <= '0;
                    r_row <= row_last ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    // line stores: read at accept, write back when the item leaves stage a
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_a_top <= r_upper_line[r_col];
            r_a_mid <= r_middle_line[r_col];
        end
        if (adv_a) begin
            r_upper_line[r_a_col]  <= r_a_mid;
            r_middle_line[r_a_col] <= r_a_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en_a) begin
            r_a_v <= acc_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_a_pix  <= s_axis_tdata;
            r_a_col  <= r_col;
            r_a_int  <= (r_row >= ROW_W'(2)) && (r_col >= CW'(2));
            r_a_last <= col_last && row_last;
        end
    end

    // window shift and sums
    always_comb begin
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = r_a_top;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = r_a_mid;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_a_pix;
        for (int c = 0; c < NUM_CH; c++) begin
            n_sum[c] = (SUM_W'(n_win[0][c*PIX_W +: PIX_W]) + SUM_W'(n_win[1][c*PIX_W +: PIX_W])
                      + SUM_W'(n_win[2][c*PIX_W +: PIX_W]))
                     + (SUM_W'(n_win[3][c*PIX_W +: PIX_W]) + SUM_W'(n_win[4][c*PIX_W +: PIX_W])
                      + SUM_W'(n_win[5][c*PIX_W +: PIX_W]))
                     + (SUM_W'(n_win[6][c*PIX_W +: PIX_W]) + SUM_W'(n_win[7][c*PIX_W +: PIX_W])
                      + SUM_W'(n_win[8][c*PIX_W +: PIX_W]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (adv_a) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else if (en_s) begin
            r_s_v <= r_a_v && r_a_int;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_s_sum  <= n_sum;
            r_s_last <= r_a_last;
        end
    end

    // divide by ten through the reciprocal
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            prod[c] = PROD_W'(r_s_sum[c]) * PROD_W'(DIV10_RECIP);
        end
        n_out_data = {ALPHA_OPAQUE,
                      prod[2][RECIP_SH +: PIX_W],
                      prod[1][RECIP_SH +: PIX_W],
                      prod[0][RECIP_SH +: PIX_W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en_out) begin
            r_out_v <= r_s_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_s_v) begin
            r_out_data <= n_out_data;
            r_out_last <= r_s_last;
        end
    end

    // an accepted item sits in stage a on the next cycle
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in |=> r_a_v)
        else $error("accepted item missing from stage a");

    // the last pixel of a frame sends the counters back to the origin
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && col_last && row_last) |=> (r_col == '0) && (r_row == '0))
        else $error("position counters did not wrap at frame end");

    // sums stay within nine full-scale pixels
    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_v |-> (r_s_sum[0] <= SUM_MAX) && (r_s_sum[1] <= SUM_MAX)
                  && (r_s_sum[2] <= SUM_MAX))
        else $error("channel sum out of range");

    // a result channel never exceeds the blur of an all-white window
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out_data[PIX_W-1:0] <= BLUR_MAX)
                    && (r_out_data[2*PIX_W-1:PIX_W] <= BLUR_MAX)
                    && (r_out_data[3*PIX_W-1:2*PIX_W] <= BLUR_MAX))
        else $error("blurred channel out of range");

endmodule

/* tb/tb.sv */
// testbench for rgb_box_blur_3x3: directed table, random frames, scoreboard on the output stream
module tb;
    import rbb_pkg::*;

    localparam int MAX_W      = 4096;
    localparam int RAND_ITEMS = 1600;
    localparam int PIPE_SLACK = 8;

    typedef struct packed {
        logic [PIX_W-1:0] red, green, blue, alpha;
        logic             frame_end;
    } blur_px_t;

    typedef enum logic {STEP_REG, STEP_PIX} step_kind_e;

    typedef struct packed {
        step_kind_e       kind;
        t_cfg_index       reg_idx;
        logic [REG_W-1:0] reg_val;
        t_pix             px;
        logic             typed;
        blur_px_t         want;
    } dir_step_t;

    localparam blur_px_t NO_RES    = '0;
    localparam blur_px_t WHITE_RES = '{8'd229, 8'd229, 8'd229, 8'hFF, 1'b1};

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    t_cfg_index       i_cfg_index = CFG_IMAGE_WIDTH;
    logic [REG_W-1:0] i_cfg_data = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             m_axis_tlast;

    // mirror of the block: line stores, window, position, registers
    logic [REG_W-1:0] cfg_width = WIDTH_RESET;
    logic [REG_W-1:0] cfg_height = HEIGHT_RESET;
    t_pix             line_far [MAX_W];
    t_pix             line_near [MAX_W];
    t_pix             win [9];
    int               pos_col = 0;
    int               pos_row = 0;

    blur_px_t         pending_blur [$];
    blur_px_t         want_px;
    int               mismatch_cnt = 0;
    bit               steady = 1'b0;

    // 3x3 frame of full white, then a 5 wide frame cut to 3 in row 0 and to 3 rows in row 3
    dir_step_t dir_tab [29] = '{
        '{STEP_REG, CFG_IMAGE_WIDTH,  13'd0, 24'h000000, 1'b0, NO_RES},
        '{STEP_REG, CFG_IMAGE_HEIGHT, 13'd2, 24'h000000, 1'b0, NO_RES},
        '{STEP_PIX, CFG_IMAGE_WIDTH,  13'd0, 24'hFFFFFF, 1'b0, NO_RES},
        '{STEP_PIX, CFG_IMAGE_WIDTH,  13'd0, 24'hFFFFFF, 1'b0, NO_RES},
        '{STEP_PIX, CFG_IMAGE_WIDTH,  13'd0, 24'hFFFFFF, 1'b0, NO_RES},
        '{STEP_PIX, CFG_IMAGE_WIDTH,  13'd0, 24'hFFFFFF, 1'b0, NO_RES},
        '{STEP_PIX, CFG_IMAGE_WIDTH,  13'd0, 24'hFFFFFF, 1'b0, NO_RES},
        '{STEP_PIX, CFG_IMAGE_WIDTH,  13'd0, 24'hFFFFFF, 1'b0, NO_RES},
        '{STEP_PIX, CFG_IMAGE_WIDTH,  13'd0, 24'hFFFFFF, 1'b0, NO_RES},
        '{STEP_PIX, CFG_IMAGE_WIDTH,  13'd0, 24'hFFFFFF, 1'b0, NO_RES},
        '{STEP_PIX, CFG_IMAGE_WIDTH,  13'd0, 24'hFFFFFF, 1'b1, WHITE_RES},
        '{STEP_REG, CFG_IMAGE_WIDTH,  13'd5, 24'h000000, 1'b0, NO_RES},
        '{STEP_REG, CFG_IMAGE_HEIGHT, 13'd5, 24'h000000, 1'b0, NO_RES},
        '{STEP_PIX, CFG_IMAGE_WIDTH,  13'd0, 24'h000000, 1'b0, NO_RES},
        '{STEP_PIX, CFG_IMAGE_WIDTH,  13'd0, 24'hFF00FF, 1'b0, NO_RES},
        '{STEP_PIX, CFG_IMAGE_WIDTH,  13'd0, 24'h123456, 1'b0, NO_RES},
        '{STEP_PIX, CFG_IMAGE_WIDTH,  13'd0, 24'hABCDEF, 1'b0, NO_RES},
        '{STEP_REG, CFG_IMAGE_WIDTH,  13'd1, 24'h000000, 1'b0, NO_RES},
        '{STEP_PIX, CFG_IMAGE_WIDTH,  13'd0, 24'h00FF00, 1'b0, NO_RES},
        '{STEP_PIX, CFG_IMAGE_WIDTH,  13'd0, 24'h808080, 1'b0, NO_RES},
        '{STEP_PIX, CFG_IMAGE_WIDTH,  13'd0, 24'h7F7F7F, 1'b0, NO_RES},
        '{STEP_PIX, CFG_IMAGE_WIDTH,  13'd0, 24'hFFFFFF, 1'b0, NO_RES},
        '{STEP_PIX, CFG_IMAGE_WIDTH,  13'd0, 24'hFFFFFF, 1'b0, NO_RES},
        '{STEP_PIX, CFG_IMAGE_WIDTH,  13'd0, 24'h010203, 1'b0, NO_RES},
        '{STEP_PIX, CFG_IMAGE_WIDTH,  13'd0, 24'hFEFDFC, 1'b0, NO_RES},
        '{STEP_REG, CFG_IMAGE_HEIGHT, 13'd3, 24'h000000, 1'b0, NO_RES},
        '{STEP_PIX, CFG_IMAGE_WIDTH,  13'd0, 24'hFFFFFF, 1'b0, NO_RES},
        '{STEP_PIX, CFG_IMAGE_WIDTH,  13'd0, 24'h000000, 1'b0, NO_RES},
        '{STEP_PIX, CFG_IMAGE_WIDTH,  13'd0, 24'h55AA55, 1'b0, NO_RES}
    };

    rgb_box_blur_3x3 DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int dim_of(input logic [REG_W-1:0] v, input int hi);
        return (v < 3) ? 3 : (v > hi) ? hi : int'(v);
    endfunction

    // advance the mirror by one pixel; returns 1 when an interior result comes out
    function automatic bit blur_step(input t_pix px, output blur_px_t res);
        int   w, h, s_r, s_g, s_b;
        t_pix top, mid;
        bit   hit;
        w = dim_of(cfg_width, MAX_W);
        h = dim_of(cfg_height, MAX_HEIGHT);
        top = line_far[pos_col];
        mid = line_near[pos_col];
        for (int r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = px;
        line_far[pos_col]  = mid;
        line_near[pos_col] = px;
        hit = (pos_row >= 2) && (pos_col >= 2);
        s_r = 0;
        s_g = 0;
        s_b = 0;
        for (int i = 0; i < 9; i++) begin
            s_r += win[i][7:0];
            s_g += win[i][15:8];
            s_b += win[i][23:16];
        end
        res = '{8'(s_r / 10), 8'(s_g / 10), 8'(s_b / 10), ALPHA_OPAQUE,
                (pos_col >= w - 1) && (pos_row >= h - 1)};
        // a counter at or past a freshly lowered limit wraps on this pixel
        if (pos_col >= w - 1) begin
            pos_col = 0;
            pos_row = (pos_row >= h - 1) ? 0 : pos_row + 1;
        end else begin
            pos_col++;
        end
        return hit;
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, want %0d", what, got, want);
        mismatch_cnt++;
    endtask

    task automatic push_pixel(input t_pix px, input logic typed, input blur_px_t typed_res);
        blur_px_t res;
        if (!steady && $urandom_range(99) < 34) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do @(posedge i_clk); while (!s_axis_tready);
        if (blur_step(px, res)) pending_blur.push_back(typed ? typed_res : res);
    endtask

    // registers only change with the pipeline drained
    task automatic load_reg(input t_cfg_index idx, input logic [REG_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        while (pending_blur.size() != 0) @(posedge i_clk);
        repeat (PIPE_SLACK) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) begin
            cfg_width = val;
        end else begin
            cfg_height = val;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_blur.size() == 0) begin
                    note_mismatch("unexpected item, red", m_axis_tdata[7:0], 0);
                end else begin
                    want_px = pending_blur.pop_front();
                    if (m_axis_tdata[7:0] != want_px.red)
                        note_mismatch("red", m_axis_tdata[7:0], want_px.red);
                    if (m_axis_tdata[15:8] != want_px.green)
                        note_mismatch("green", m_axis_tdata[15:8], want_px.green);
                    if (m_axis_tdata[23:16] != want_px.blue)
                        note_mismatch("blue", m_axis_tdata[23:16], want_px.blue);
                    if (m_axis_tdata[31:24] != want_px.alpha)
                        note_mismatch("alpha", m_axis_tdata[31:24], want_px.alpha);
                    if (m_axis_tlast != want_px.frame_end)
                        note_mismatch("frame end", m_axis_tlast, want_px.frame_end);
                end
            end
            m_axis_tready <= steady || ($urandom_range(99) >= 34);
        end
    end

    initial begin
        t_pix             px;
        logic [REG_W-1:0] new_dim;
        int               phase, rand_px, n, cut, wait_cnt;
        bit               big, bright;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == STEP_REG) begin
                load_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            end else begin
                push_pixel(dir_tab[i].px, dir_tab[i].typed, dir_tab[i].want);
            end
        end

        // one random frame per pass; pass 4 opens past the widest width and pass 12
        // past the tallest height, both cut short
        phase = 0;
        rand_px = 0;
        while (rand_px < RAND_ITEMS) begin
            big = (phase == 4) || (phase == 12);
            steady = (phase >= 20) && (phase < 30);
            if (phase == 4) begin
                load_reg(CFG_IMAGE_WIDTH, 13'd4097);
                load_reg(CFG_IMAGE_HEIGHT, 13'd3);
            end else if (phase == 12) begin
                load_reg(CFG_IMAGE_WIDTH, 13'd3);
                load_reg(CFG_IMAGE_HEIGHT, '1);
            end else begin
                if (phase == 5 || $urandom_range(1)) begin
                    case ($urandom_range(9))
                        0: begin
                            new_dim = REG_W'($urandom_range(2));
                        end
                        1: begin
                            new_dim = REG_W'($urandom_range(13, 40));
                        end
                        default: begin
                            new_dim = REG_W'($urandom_range(3, 12));
                        end
                    endcase
                    load_reg(CFG_IMAGE_WIDTH, new_dim);
                end
                if (phase == 13 || $urandom_range(1)) begin
                    new_dim = ($urandom_range(7) == 0) ? REG_W'($urandom_range(2))
                                                       : REG_W'($urandom_range(3, 7));
                    load_reg(CFG_IMAGE_HEIGHT, new_dim);
                end
            end
            bright = ($urandom_range(7) == 0);
            cut = big ? $urandom_range(5, 30)
                      : (($urandom_range(3) == 0) ? $urandom_range(1, 40) : 0);
            n = 0;
            do begin
                // mid-frame change: any height, but width only shrinks so rows above stay written
                if (n != 0 && n == cut) begin
                    if (phase == 4) begin
                        load_reg(CFG_IMAGE_WIDTH, REG_W'($urandom_range(3, 12)));
                    end else if (phase == 12 || $urandom_range(1)) begin
                        load_reg(CFG_IMAGE_HEIGHT, REG_W'($urandom_range(8)));
                    end else begin
                        load_reg(CFG_IMAGE_WIDTH,
                                 REG_W'($urandom_range(dim_of(cfg_width, MAX_W))));
                    end
                end
                px = bright ? {8'($urandom_range(220, 255)), 8'($urandom_range(220, 255)),
                               8'($urandom_range(220, 255))}
                            : t_pix'($urandom);
                push_pixel(px, 1'b0, NO_RES);
                n++;
                rand_px++;
            end while (pos_row != 0 || pos_col != 0);
            phase++;
        end

        s_axis_tvalid <= 1'b0;
        wait_cnt = 0;
        while (pending_blur.size() != 0 && wait_cnt < 20000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (PIPE_SLACK) @(posedge i_clk);
        if (pending_blur.size() != 0)
            note_mismatch("items never delivered", pending_blur.size(), 0);
        if (mismatch_cnt == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb failed");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/rbb_pkg.sv
hw/rtl/rgb_box_blur_3x3.sv
tb/tb.sv
